/* sv/pes_pkg.sv */
// shared constants and helper functions for the particle euler step block
`default_nettype none
package pes_pkg;
    localparam int unsigned MassW  = 31;
    localparam int unsigned DragW  = 16;
    localparam int unsigned BoundW = 16;
    localparam int unsigned DataW  = 32;
    localparam int unsigned ActW   = 3;
    localparam int unsigned DtW    = 16;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [MassW-1:0]  MASS_RESET = 31'd13107200;
    localparam logic [DragW-1:0]  DRAG_RESET = 16'd66;
    localparam logic [BoundW-1:0] BMIN_RESET = 16'sd200;
    localparam logic [BoundW-1:0] BMAX_RESET = 16'sd600;

    localparam logic [CfgIdxW-1:0] REG_MASS = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DRAG = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_BMIN = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_BMAX = 2'd3;

    localparam logic [ActW-1:0] ACT_TICK   = 3'd0;
    localparam logic [ActW-1:0] ACT_FORCE  = 3'd1;
    localparam logic [ActW-1:0] ACT_TOWARD = 3'd2;
    localparam logic [ActW-1:0] ACT_BOUNDS = 3'd3;
    localparam logic [ActW-1:0] ACT_FREEZE = 3'd4;
    localparam logic [ActW-1:0] ACT_SETPOS = 3'd5;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sh07FFFFFFF) r = 32'sh7FFFFFFF;
            else if (v < -34'sh080000000) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

    // saturate a 49-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
        logic signed [31:0] r;
        begin
            if (v > 49'sh07FFFFFFF) r = 32'sh7FFFFFFF;
            else if (v < -49'sh080000000) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

    // floor((p + 2^15) / 2^16) of a 64-bit signed product
    function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] q;
        begin
            q = p + 64'sd32768;
            return q[63:16];
        end
    endfunction
endpackage
`default_nettype wire

/* sv/pes_lane.sv */
// one axis lane: the multiply steps and the pull division for one axis
`default_nettype none
module pes_lane (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               mul_go,
    input  wire logic signed [32:0] mul_a,
    input  wire logic signed [32:0] mul_b,
    output logic signed [63:0]      mul_p_reg,
    input  wire logic               div_go,
    input  wire logic [31:0]        div_num,
    input  wire logic [31:0]        div_den,
    output logic                    div_busy,
    output logic [31:0]             div_q
);
    // one registered 33x33 multiply per cycle
    logic signed [65:0] prod;
    assign prod = mul_a * mul_b;
    always_ff @(posedge aclk) begin
        if (mul_go) mul_p_reg <= prod[63:0];
    end

    // restoring divider: (num << 30) / den, one quotient bit a cycle
    logic [62:0] rem_reg, rem_next;
    logic [61:0] dvd_reg, dvd_next;
    logic [31:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] den_reg;
    logic [62:0] trial;
    always_comb begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg[61:0], dvd_reg[61]};
        if (div_go) begin
            rem_next = '0;
            dvd_next = {div_num, 30'd0};
            q_next   = '0;
            cnt_next = 6'd62;
        end else if (cnt_reg != 6'd0) begin
            dvd_next = {dvd_reg[60:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (trial >= {31'd0, den_reg}) begin
                rem_next = trial - {31'd0, den_reg};
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[30:0], 1'b0};
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        if (div_go) den_reg <= div_den;
    end
    assign div_busy = (cnt_reg != 6'd0);
    assign div_q    = q_reg;
endmodule
`default_nettype wire

/* sv/pes_isqrt.sv */
// iterative integer square root, one result bit per cycle
`default_nettype none
module pes_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        go,
    input  wire logic [63:0] val,
    output logic             busy,
    output logic [31:0]      root
);
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [5:0]  k_reg, k_next;
    logic [63:0] bitv;
    always_comb begin
        v_next = v_reg;
        r_next = r_reg;
        k_next = k_reg;
        bitv   = 64'd1 << {k_reg[4:0], 1'b0};
        if (go) begin
            v_next = val;
            r_next = '0;
            k_next = 6'd32;
        end else if (k_reg != 6'd0) begin
            bitv   = 64'd1 << {k_reg[4:0] - 5'd1, 1'b0};
            k_next = k_reg - 6'd1;
            if (v_reg >= r_reg + bitv) begin
                v_next = v_reg - (r_reg + bitv);
                r_next = (r_reg >> 1) + bitv;
            end else begin
                r_next = r_reg >> 1;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) k_reg <= '0;
        else k_reg <= k_next;
        v_reg <= v_next;
        r_reg <= r_next;
    end
    assign busy = (k_reg != 6'd0);
    assign root = r_reg[31:0];
endmodule
`default_nettype wire

/* sv/particle_euler_step.sv */
// particle euler step top level: sequencer, state, two axis lanes, square root, merge
// add_force_toward runs the mass multiply, square root, divide, then merge multiply
// throughput: one item at a time; the next beat is taken once the result leaves
// the result register; the divider and square root iterations set the long case
// reset: aresetn synchronous active low clears state to zero and registers to
// their defaults (mass 200.0, drag 66, box 200..600)
`default_nettype none
module particle_euler_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic signed [31:0] s_vec_x,
    input  wire logic signed [31:0] s_vec_y,
    input  wire logic signed [31:0] s_force_scale,
    input  wire logic [15:0] s_dt,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_out_pos_x,
    output logic signed [31:0] m_out_pos_y,
    output logic signed [31:0] m_out_vel_x,
    output logic signed [31:0] m_out_vel_y
);
    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_M1   = 11'b00000000010,
        ST_M2   = 11'b00000000100,
        ST_M3   = 11'b00000001000,
        ST_M4   = 11'b00000010000,
        ST_SQ   = 11'b00000100000,
        ST_SQW  = 11'b00001000000,
        ST_T    = 11'b00010000000,
        ST_DIV  = 11'b00100000000,
        ST_PM   = 11'b01000000000,
        ST_OUT  = 11'b10000000000
    } state_t;

    state_t st_reg, st_next;

    // configuration registers
    logic [30:0] mass_reg;
    logic [15:0] drag_reg;
    logic signed [15:0] bmin_reg, bmax_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg <= pes_pkg::MASS_RESET;
            drag_reg <= pes_pkg::DRAG_RESET;
            bmin_reg <= pes_pkg::BMIN_RESET;
            bmax_reg <= pes_pkg::BMAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                pes_pkg::REG_MASS: mass_reg <= cfg_data;
                pes_pkg::REG_DRAG: drag_reg <= cfg_data[15:0];
                pes_pkg::REG_BMIN: bmin_reg <= cfg_data[15:0];
                pes_pkg::REG_BMAX: bmax_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // particle state and latched beat
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, ax_reg, ay_reg;
    logic [2:0]  act_reg;
    logic signed [31:0] ix_reg, iy_reg, isc_reg;
    logic [15:0] dt_reg;
    // add_force_toward intermediates
    logic [32:0] mx_reg, my_reg;          // magnitudes, halved if large
    logic        nx_reg, ny_reg;          // sign of d xor sign of scale
    logic [63:0] t_reg;                   // mass*|scale| >> 16
    logic        out_v_reg;
    logic        mul_seen_reg;

    // lane controls
    logic               mul_go;
    logic signed [32:0] ma_x, mb_x, ma_y, mb_y;
    logic signed [63:0] p_x, p_y;
    logic               div_go;
    logic               bx, by;
    logic [31:0]        qx, qy;
    logic [31:0]        root;
    logic               sq_busy, sq_go;
    logic [63:0]        sq_val;

    pes_lane u_lane_x (.aclk, .aresetn, .mul_go, .mul_a(ma_x), .mul_b(mb_x),
        .mul_p_reg(p_x), .div_go, .div_num(mx_reg[31:0]), .div_den(root),
        .div_busy(bx), .div_q(qx));
    pes_lane u_lane_y (.aclk, .aresetn, .mul_go, .mul_a(ma_y), .mul_b(mb_y),
        .mul_p_reg(p_y), .div_go, .div_num(my_reg[31:0]), .div_den(root),
        .div_busy(by), .div_q(qy));
    pes_isqrt u_sqrt (.aclk, .aresetn, .go(sq_go), .val(sq_val),
        .busy(sq_busy), .root);

    // differences toward target
    logic signed [32:0] dx, dy;
    logic [32:0] adx, ady;
    logic        big;
    assign dx  = {s_vec_x[31], s_vec_x} - {px_reg[31], px_reg};
    assign dy  = {s_vec_y[31], s_vec_y} - {py_reg[31], py_reg};
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);
    assign big = adx[32] | ady[32] | adx[31] | ady[31];
    assign sq_val = 64'(mx_reg[31:0]) * 64'(mx_reg[31:0]) + 64'(my_reg[31:0]) * 64'(my_reg[31:0]);

    logic [31:0] sabs;
    assign sabs = isc_reg[31] ? 32'(-isc_reg) : 32'(isc_reg);

    // merge: pulled magnitude per axis, high part of t times u plus the
    // lane product of the low 30 bits of t and u
    function automatic logic signed [31:0] pull(input logic [17:0] t_hi,
                                                input logic [31:0] u,
                                                input logic signed [63:0] lo_p,
                                                input logic [32:0] m, input logic ng,
                                                input logic signed [31:0] acc);
        logic [49:0] hp;
        logic [63:0] mm;
        logic signed [33:0] add;
        begin
            hp = 50'(t_hi) * 50'(u);
            mm = 64'(hp) + 64'(lo_p[63:30]);
            if (mm > 64'h7FFFFFFF) mm = 64'h7FFFFFFF;
            add = ng ? -34'(mm[31:0]) : 34'(mm[31:0]);
            if (m == 33'd0) add = '0;
            return pes_pkg::sat34(34'(acc) + add);
        end
    endfunction

    // box test: upper edge first, then lower edge on the updated velocity
    function automatic logic signed [31:0] bounce(input logic signed [31:0] pos,
                                                  input logic signed [31:0] vel);
        logic signed [31:0] v;
        begin
            v = vel;
            if (pos > $signed({bmax_reg, 16'd0}) && v > 0) v = -v;
            if (pos < $signed({bmin_reg, 16'd0}) && v < 0) v = pes_pkg::sat34(-34'(v));
            return v;
        end
    endfunction

    always_comb begin
        st_next = st_reg;
        mul_go = 1'b0; div_go = 1'b0; sq_go = 1'b0;
        ma_x = 33'(vx_reg); mb_x = 33'(dt_reg);
        ma_y = 33'(vy_reg); mb_y = 33'(dt_reg);
        case (st_reg)
            ST_IDLE: ;
            ST_M1: begin
                mul_go = 1'b1;
                if (act_reg == pes_pkg::ACT_FORCE) begin
                    ma_x = 33'(ix_reg); mb_x = 33'({2'b0, mass_reg});
                    ma_y = 33'(iy_reg); mb_y = 33'({2'b0, mass_reg});
                end else if (act_reg == pes_pkg::ACT_TOWARD) begin
                    ma_x = 33'({2'b0, mass_reg}); mb_x = 33'({1'b0, sabs});
                end
                st_next = (act_reg == pes_pkg::ACT_TICK) ? ST_M2 :
                          (act_reg == pes_pkg::ACT_TOWARD) ? ST_T : ST_OUT;
            end
            ST_M2: begin
                mul_go = 1'b1;
                ma_x = 33'(ax_reg); ma_y = 33'(ay_reg);
                st_next = ST_M3;
            end
            // velocity picks up accel*dt here, drag uses the new velocity
            ST_M3: st_next = ST_M4;
            ST_M4: begin
                mul_go = 1'b1;
                ma_x = 33'(vx_reg); mb_x = 33'({17'd0, drag_reg});
                ma_y = 33'(vy_reg); mb_y = 33'({17'd0, drag_reg});
                st_next = ST_OUT;
            end
            ST_T: begin
                sq_go = 1'b1;
                st_next = ST_SQ;
            end
            ST_SQ: st_next = ST_SQW;
            ST_SQW: if (!sq_busy) begin
                div_go = 1'b1;
                st_next = ST_DIV;
            end
            ST_DIV: if (!bx && !by) st_next = ST_PM;
            ST_PM: begin
                mul_go = 1'b1;
                ma_x = 33'({3'b0, t_reg[29:0]}); mb_x = 33'({1'b0, qx});
                ma_y = 33'({3'b0, t_reg[29:0]}); mb_y = 33'({1'b0, qy});
                st_next = ST_OUT;
            end
            ST_OUT: if (!out_v_reg) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
        if (st_reg == ST_IDLE && s_valid && !out_v_reg) begin
            st_next = ST_M1;
            if (s_action != pes_pkg::ACT_TICK && s_action != pes_pkg::ACT_FORCE &&
                s_action != pes_pkg::ACT_TOWARD) st_next = ST_OUT;
            if (s_action == pes_pkg::ACT_TOWARD && adx == 33'd0 && ady == 33'd0)
                st_next = ST_OUT;
        end
    end

    assign s_ready = (st_reg == ST_IDLE) && !out_v_reg;

    logic signed [47:0] r_x, r_y;
    assign r_x = pes_pkg::rnd16(p_x);
    assign r_y = pes_pkg::rnd16(p_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            px_reg <= '0; py_reg <= '0; vx_reg <= '0; vy_reg <= '0;
            ax_reg <= '0; ay_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (out_v_reg && m_ready) out_v_reg <= 1'b0;
            if (st_reg == ST_OUT && !out_v_reg) out_v_reg <= 1'b1;
            if (s_valid && s_ready) begin
                case (s_action)
                    pes_pkg::ACT_BOUNDS: begin
                        vx_reg <= bounce(px_reg, vx_reg);
                        vy_reg <= bounce(py_reg, vy_reg);
                    end
                    pes_pkg::ACT_FREEZE: begin
                        vx_reg <= '0; vy_reg <= '0; ax_reg <= '0; ay_reg <= '0;
                    end
                    pes_pkg::ACT_SETPOS: begin
                        px_reg <= s_vec_x; py_reg <= s_vec_y;
                    end
                    default: ;
                endcase
            end
            // accumulate each product in the state that follows its multiply
            case (st_reg)
                ST_M2: begin
                    px_reg <= pes_pkg::sat34(34'(px_reg) + 34'(r_x));
                    py_reg <= pes_pkg::sat34(34'(py_reg) + 34'(r_y));
                end
                ST_M3: begin
                    vx_reg <= pes_pkg::sat34(34'(vx_reg) + 34'(r_x));
                    vy_reg <= pes_pkg::sat34(34'(vy_reg) + 34'(r_y));
                end
                ST_OUT: if (!out_v_reg) begin
                    if (act_reg == pes_pkg::ACT_TICK) begin
                        vx_reg <= pes_pkg::sat34(34'(vx_reg) - 34'(r_x));
                        vy_reg <= pes_pkg::sat34(34'(vy_reg) - 34'(r_y));
                        ax_reg <= '0; ay_reg <= '0;
                    end else if (act_reg == pes_pkg::ACT_FORCE && mul_seen_reg) begin
                        ax_reg <= pes_pkg::sat49(49'(ax_reg) + 49'(r_x));
                        ay_reg <= pes_pkg::sat49(49'(ay_reg) + 49'(r_y));
                    end else if (act_reg == pes_pkg::ACT_TOWARD && mul_seen_reg) begin
                        ax_reg <= pull(t_reg[47:30], qx, p_x, mx_reg, nx_reg, ax_reg);
                        ay_reg <= pull(t_reg[47:30], qy, p_y, my_reg, ny_reg, ay_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    // latched beat and toward-target intermediates
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg <= s_action; ix_reg <= s_vec_x; iy_reg <= s_vec_y;
            isc_reg <= s_force_scale; dt_reg <= s_dt;
            mx_reg <= big ? (adx >> 1) : adx;
            my_reg <= big ? (ady >> 1) : ady;
            nx_reg <= dx[32] ^ s_force_scale[31];
            ny_reg <= dy[32] ^ s_force_scale[31];
            mul_seen_reg <= 1'b0;
        end
        if (st_reg == ST_M1) mul_seen_reg <= 1'b1;
        if (st_reg == ST_T) t_reg <= 64'(p_x[63:16]) & 64'h0000FFFFFFFFFFFF;
    end

    assign m_valid     = out_v_reg;
    assign m_out_pos_x = px_reg;
    assign m_out_pos_y = py_reg;
    assign m_out_vel_x = vx_reg;
    assign m_out_vel_y = vy_reg;

    // no beat taken while a result waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> !s_ready) else $error("beat accepted while result pending");
    // a new result follows only from the output state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_v_reg) |-> $past(st_reg == ST_OUT)) else $error("result without output step");
    // divider finishes before result for toward-target
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT) |-> (!bx && !by)) else $error("result before divide done");
endmodule
`default_nettype wire
